// ===== sv/ped_pkg.sv =====
// Package for the printable escape decoder: escape phase type, character codes
// and the hex digit decode helper.
// No dependencies.
`default_nettype none

package ped_pkg;

   // Escape phase of the decoder.
   typedef enum logic [1:0] {
      PH_NORMAL   = 2'd0,
      PH_AFTER_BS = 2'd1,
      PH_HEX_HIGH = 2'd2,
      PH_HEX_LOW  = 2'd3
   } phase_type;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_X   = 8'h78;
   localparam logic [7:0] CH_UPPER_X   = 8'h58;

   // Result of decoding one character as a hex digit.
   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   // Digits 0-9 take the low nibble; A-F and a-f both have a low nibble of
   // 1..6, so adding nine gives 10..15.
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok  = 1'b0;
      h.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.ok  = 1'b1;
         h.val = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         h.ok  = 1'b1;
         h.val = c[3:0] + 4'd9;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

// ===== sv/printable_escape_decoder_core.sv =====
// Top level of the printable escape decoder: phase register, decode logic and
// the result output register.
// Depends on ped_pkg.
`default_nettype none

// The decoder takes one character word per cycle and turns an escaped text
// back into raw bytes. Ordinary characters pass through; a backslash pair
// gives one backslash byte; a backslash, x or X and two hex digits give that
// byte. Characters inside an escape give no result until the escape finishes.
// A bad escape letter, a non-hex digit or a text that ends inside an escape
// gives one error word with a zero byte. Each character is decoded in the
// cycle it is accepted and its result, if any, appears in the output register
// on the next cycle, so one character is accepted every cycle; the only limit
// is the single output register, which holds back input only while a result
// waits there and the result side stalls.
module printable_escape_decoder_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_is_last,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_byte_out,
   output      logic       rsp_error,
   output      logic       rsp_last
);
   import ped_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] high_nibble_ff, high_nibble_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_error_ff, rsp_error_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       accept;
   logic       emit;
   logic       emit_err;
   logic [7:0] emit_byte;
   hex_type    hex;

   // Input is held back only while a result waits and cannot leave.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign hex       = hex_decode(req_char_in);

   // Next phase and the stored high digit.
   always_comb begin
      phase_in       = phase_ff;
      high_nibble_in = high_nibble_ff;
      if (accept) begin
         phase_in       = PH_NORMAL;
         high_nibble_in = 4'd0;
         case (phase_ff)
            PH_NORMAL: begin
               if (req_char_in == CH_BACKSLASH && !req_is_last) begin
                  phase_in = PH_AFTER_BS;
               end
            end
            PH_AFTER_BS: begin
               if ((req_char_in == CH_LOWER_X || req_char_in == CH_UPPER_X) &&
                   !req_is_last) begin
                  phase_in = PH_HEX_HIGH;
               end
            end
            PH_HEX_HIGH: begin
               if (hex.ok && !req_is_last) begin
                  phase_in       = PH_HEX_LOW;
                  high_nibble_in = hex.val;
               end
            end
            PH_HEX_LOW: begin
               phase_in = PH_NORMAL;
            end
            default: begin
               phase_in = PH_NORMAL;
            end
         endcase
      end
   end

   // Whether this character produces a word, and what it carries.
   always_comb begin
      emit      = 1'b1;
      emit_err  = 1'b0;
      emit_byte = req_char_in;
      case (phase_ff)
         PH_NORMAL: begin
            if (req_char_in == CH_BACKSLASH) begin
               emit     = req_is_last;
               emit_err = 1'b1;
            end
         end
         PH_AFTER_BS: begin
            if (req_char_in == CH_BACKSLASH) begin
               emit_byte = CH_BACKSLASH;
            end else if (req_char_in == CH_LOWER_X || req_char_in == CH_UPPER_X) begin
               emit     = req_is_last;
               emit_err = 1'b1;
            end else begin
               emit_err = 1'b1;
            end
         end
         PH_HEX_HIGH: begin
            emit     = ~hex.ok | req_is_last;
            emit_err = 1'b1;
         end
         PH_HEX_LOW: begin
            emit_err  = ~hex.ok;
            emit_byte = {high_nibble_ff, hex.val};
         end
         default: begin
            emit_err = 1'b1;
         end
      endcase
      if (emit_err) begin
         emit_byte = 8'd0;
      end
   end

   // Output register: loads a new word when an accepted character emits one, empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_error_in = rsp_error_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_error_in = emit_err;
         rsp_last_in  = req_is_last;
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_NORMAL;
         high_nibble_ff <= 4'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         high_nibble_ff <= high_nibble_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_byte_ff  <= rsp_byte_in;
      rsp_error_ff <= rsp_error_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_byte_out = rsp_byte_ff;
   assign rsp_error    = rsp_error_ff;
   assign rsp_last     = rsp_last_ff;

   // An ordinary character in normal text comes straight out next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_NORMAL && req_char_in != CH_BACKSLASH)
      |=> (rsp_valid && !rsp_error && rsp_byte_out == $past(req_char_in)))
      else $error("plain character not passed through");

   // The last character of a text always leaves the decoder in normal text.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_is_last) |=> (phase_ff == PH_NORMAL && rsp_valid && rsp_last))
      else $error("text end did not close the escape");

   // The high digit is held only while the low digit is awaited.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HEX_LOW) |-> (high_nibble_ff == 4'd0))
      else $error("stale high digit");

   // An error word never carries a byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_byte_out == 8'd0))
      else $error("error word with nonzero byte");

endmodule

`default_nettype wire
